/* design/psh_pkg.sv */
// Shared types and constants for the per-source hit counter.
// No dependencies; compiled first.
package psh_pkg;

  localparam int ADDR_BITS = 32;
  localparam int HIT_BITS  = 32;

  typedef struct packed {
    logic live;
    logic matched;
    logic inserted;
  } probe_t;

endpackage

/* design/psh_if.sv */
// Request and response channel interfaces for the per-source hit counter.
// Depends on psh_pkg for field widths.
interface psh_req_if;
  import psh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] source_address;

  modport source (output valid, output source_address, input ready);
  modport sink   (input valid, input source_address, output ready);
endinterface

interface psh_resp_if;
  import psh_pkg::*;
  logic                valid;
  logic                ready;
  logic [HIT_BITS-1:0] hit_count;
  logic                new_entry;
  logic                table_full;

  modport source (output valid, output hit_count, output new_entry, output table_full,
                  input ready);
  modport sink   (input valid, input hit_count, input new_entry, input table_full,
                  output ready);
endinterface

/* design/psh_cell.sv */
// One table entry of the hit counter chain: holds an address and its count,
// and passes the search probe on to its neighbour each cycle. Uses psh_pkg.
module psh_cell
  import psh_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ADDR_BITS-1:0]  key,
  input  logic                  in_use,
  input  probe_t                probe_in,
  input  logic [COUNT_BITS-1:0] count_in,
  output probe_t                probe_out,
  output logic [COUNT_BITS-1:0] count_out
);

  logic [ADDR_BITS-1:0]  address;
  logic [COUNT_BITS-1:0] hits;
  logic [COUNT_BITS-1:0] hits_next;
  logic [COUNT_BITS-1:0] count_next;
  probe_t                probe_next;
  logic                  write_addr;
  logic                  write_hits;

  always_comb begin
    probe_next = probe_in;
    count_next = count_in;
    hits_next  = hits;
    write_addr = 1'b0;
    write_hits = 1'b0;
    if (probe_in.live && !probe_in.matched && !probe_in.inserted) begin
      if (in_use) begin
        if (address == key) begin
          probe_next.matched = 1'b1;
          hits_next  = (hits == '1) ? hits : hits + COUNT_BITS'(1);
          write_hits = 1'b1;
          count_next = hits_next;
        end
      end else begin
        probe_next.inserted = 1'b1;
        hits_next  = COUNT_BITS'(1);
        write_addr = 1'b1;
        write_hits = 1'b1;
        count_next = COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    count_out <= count_next;
    if (write_addr) begin
      address <= key;
    end
    if (write_hits) begin
      hits <= hits_next;
    end
  end

endmodule

/* design/per_source_hit_counter.sv */
// Channel  | Direction | Payload
// req      | in        | source_address[31:0]
// resp     | out       | hit_count[31:0], new_entry, table_full
//
// A request is taken only once the previous search has ended and its result
// has left ST_POST; the probe walks the cell chain one entry per cycle.
// The response register is held until taken; a response still stalled when
// the next search ends holds that request and delays the acceptance after it.
// Synchronous reset empties the table at once.
// Top level of the per-source hit counter; uses psh_pkg, psh_if, psh_cell.
module per_source_hit_counter
  import psh_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_BITS    = 32
) (
  input  logic       clk,
  input  logic       rst,
  psh_req_if.sink    req,
  psh_resp_if.source resp
);

  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_POST = 3'b100
  } state_t;

  state_t                state;
  logic [USED_W-1:0]     entries_used;
  logic [ADDR_BITS-1:0]  key;
  probe_t                head;
  probe_t                probe_chain [TABLE_ENTRIES+1];
  logic [COUNT_BITS-1:0] count_chain [TABLE_ENTRIES+1];
  logic [COUNT_BITS-1:0] pend_count;
  logic                  pend_new;
  logic                  pend_full;
  logic [HIT_BITS-1:0]   pend_shown;
  logic                  out_valid;
  logic [HIT_BITS-1:0]   out_count;
  logic                  out_new;
  logic                  out_full;
  logic                  accept;
  probe_t                tail;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign tail      = probe_chain[TABLE_ENTRIES];

  assign probe_chain[0] = head;
  assign count_chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    psh_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_use    (USED_W'(i) < entries_used),
      .probe_in  (probe_chain[i]),
      .count_in  (count_chain[i]),
      .probe_out (probe_chain[i+1]),
      .count_out (count_chain[i+1])
    );
  end

  if (COUNT_BITS >= HIT_BITS) begin : g_wide
    assign pend_shown = pend_count[HIT_BITS-1:0];
  end else begin : g_narrow
    assign pend_shown = {{(HIT_BITS-COUNT_BITS){1'b0}}, pend_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entries_used <= '0;
      head         <= '0;
      out_valid    <= 1'b0;
    end else begin
      head <= probe_t'{live: accept, matched: 1'b0, inserted: 1'b0};
      if (out_valid && resp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.live) begin
            state <= ST_POST;
            if (tail.inserted) begin
              entries_used <= entries_used + USED_W'(1);
            end
          end
        end
        ST_POST: begin
          if (!out_valid || resp.ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= req.source_address;
    end
    if (state == ST_SCAN && tail.live) begin
      pend_count <= (tail.matched || tail.inserted) ? count_chain[TABLE_ENTRIES] : '0;
      pend_new   <= tail.inserted;
      pend_full  <= !tail.matched && !tail.inserted;
    end
    if (state == ST_POST && (!out_valid || resp.ready)) begin
      out_count <= pend_shown;
      out_new   <= pend_new;
      out_full  <= pend_full;
    end
  end

  assign resp.valid      = out_valid;
  assign resp.hit_count  = out_count;
  assign resp.new_entry  = out_new;
  assign resp.table_full = out_full;

endmodule

/* design/psh_checker.sv */
// Port-level checks for the per-source hit counter, bound to the top level.
// Depends on psh_pkg and per_source_hit_counter.
module psh_checker
  import psh_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                resp_valid,
  input logic                resp_ready,
  input logic [HIT_BITS-1:0] hit_count,
  input logic                new_entry,
  input logic                table_full
);

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(hit_count)
      && $stable(new_entry) && $stable(table_full))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during a search");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> !(new_entry && table_full))
    else $error("new entry and full both set");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    resp_valid && new_entry |-> hit_count == HIT_BITS'(1))
    else $error("new entry without count of one");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    resp_valid && table_full |-> hit_count == '0)
    else $error("full response with non-zero count");

endmodule

bind per_source_hit_counter psh_checker u_psh_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .hit_count  (resp.hit_count),
  .new_entry  (resp.new_entry),
  .table_full (resp.table_full)
);

/* test/tb.sv */
// Self-checking testbench for per_source_hit_counter: directed then random requests
// with the default counter width, each response checked against an in-bench table model.
// Depends on psh_pkg, psh_if and the design sources; reads no files.
module tb;
  import psh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES   = 64;
  localparam int COUNT_WIDTH     = 32;
  localparam int RANDOM_REQUESTS = 1530;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [HIT_BITS-1:0] hit_count;
    logic                new_entry;
    logic                table_full;
  } hit_result_t;

  typedef struct {
    logic [ADDR_BITS-1:0] address;
    bit                   drain;
  } request_t;

  logic clk;
  logic rst;

  psh_req_if  req();
  psh_resp_if resp();

  per_source_hit_counter #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .resp(resp)
  );

  logic [ADDR_BITS-1:0]   table_key  [TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0] table_hits [TABLE_ENTRIES];
  int                     table_used = 0;

  request_t    pending_requests[$];
  hit_result_t expected_hits[$];
  request_t    next_req;

  bit [ADDR_BITS-1:0] issued_keys[$];
  bit                 issued_stored[bit [ADDR_BITS-1:0]];
  bit [ADDR_BITS-1:0] refused_keys[$];

  logic req_taken  = 1'b0;
  logic resp_taken = 1'b0;
  int   send_gap   = 0;
  int   recv_stall = 0;
  bit   send_calm  = 1'b0;
  bit   recv_calm  = 1'b0;
  int   errors     = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int idle_cycles(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic hit_result_t tally_address(logic [ADDR_BITS-1:0] address);
    hit_result_t res;
    int          slot;
    res  = '0;
    slot = -1;
    for (int i = 0; i < table_used; i++) begin
      if (table_key[i] == address) slot = i;
    end
    if (slot >= 0) begin
      if (table_hits[slot] != COUNT_MAX) table_hits[slot] = table_hits[slot] + 1'b1;
      res.hit_count = HIT_BITS'(table_hits[slot]);
    end else if (table_used < TABLE_ENTRIES) begin
      table_key[table_used]  = address;
      table_hits[table_used] = COUNT_WIDTH'(1);
      table_used++;
      res.hit_count = HIT_BITS'(1);
      res.new_entry = 1'b1;
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic queue_request(input logic [ADDR_BITS-1:0] address, input bit drain);
    request_t item;
    item.address = address;
    item.drain   = drain;
    pending_requests.push_back(item);
    if (!issued_stored.exists(address)) begin
      if (issued_keys.size() < TABLE_ENTRIES) begin
        issued_keys.push_back(address);
        issued_stored[address] = 1'b1;
      end else begin
        refused_keys.push_back(address);
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req.valid          <= 1'b0;
      req.source_address <= '0;
      send_gap = 0;
    end else if (!(req.valid && !req_taken)) begin
      if (req_taken) send_gap = idle_cycles(send_calm);
      if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain && expected_hits.size() > 0)) begin
        next_req = pending_requests.pop_front();
        req.valid          <= 1'b1;
        req.source_address <= next_req.address;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      resp.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (resp_taken) recv_stall = idle_cycles(recv_calm);
      else if (resp.valid && recv_stall > 0) recv_stall--;
      resp.ready <= (recv_stall == 0);
    end
  end

  always @(posedge clk) begin
    hit_result_t want;
    req_taken  <= !rst && req.valid && req.ready;
    resp_taken <= !rst && resp.valid && resp.ready;
    if (!rst && req.valid && req.ready) begin
      expected_hits.push_back(tally_address(req.source_address));
    end
    if (!rst && resp.valid && resp.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = expected_hits.pop_front();
        if (resp.hit_count !== want.hit_count)
          report_mismatch($sformatf("hit_count %0d, want %0d", resp.hit_count,
                                    want.hit_count));
        if (resp.new_entry !== want.new_entry)
          report_mismatch($sformatf("new_entry %b, want %b", resp.new_entry,
                                    want.new_entry));
        if (resp.table_full !== want.table_full)
          report_mismatch($sformatf("table_full %b, want %b", resp.table_full,
                                    want.table_full));
      end
    end
  end

  initial begin
    int                   pick;
    logic [ADDR_BITS-1:0] address;
    rst = 1'b1;

    queue_request(32'h0000_0000, 1'b0);
    queue_request(32'hFFFF_FFFF, 1'b0);
    queue_request(32'h0000_0000, 1'b0);
    queue_request(32'hFFFF_FFFF, 1'b0);
    queue_request(32'h0000_0001, 1'b0);
    queue_request(32'h8000_0000, 1'b0);
    queue_request(32'h7FFF_FFFF, 1'b0);
    queue_request(32'hFFFF_FFFE, 1'b0);
    queue_request(32'h5555_5555, 1'b0);
    queue_request(32'hAAAA_AAAA, 1'b0);
    queue_request(32'hC0A8_0001, 1'b0);
    queue_request(32'hC0A8_0001, 1'b0);
    queue_request(32'h0000_0000, 1'b0);
    queue_request(32'h5555_5555, 1'b0);
    queue_request(32'h0A00_0001, 1'b0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        address = issued_keys[0];
      else if (pick < 70)
        address = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
      else if (pick < 80 && refused_keys.size() > 0)
        address = refused_keys[$urandom_range(0, refused_keys.size() - 1)];
      else
        address = $urandom;
      queue_request(address, n == 0 || n == RANDOM_REQUESTS / 2);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() > 0 || req.valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (TABLE_ENTRIES + 10) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/psh_pkg.sv
design/psh_if.sv
design/psh_cell.sv
design/per_source_hit_counter.sv
design/psh_checker.sv
test/tb.sv
